>>> rtl/ttc_pkg.sv
// Shared types and constants of the thermistor temperature converter.
package ttc_pkg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SAMPLES = 2'd1,
        ST_MEAN_RANGE = 2'd2,
        ST_BAD_DENOM  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_PULLUP    = 3'd0,
        REG_COEF_A    = 3'd1,
        REG_COEF_B    = 3'd2,
        REG_COEF_C    = 3'd3,
        REG_SENSOR_ID = 3'd4
    } t_reg_idx;

    // sideband that rides through the reciprocal divider
    typedef struct packed {
        t_status st;
        logic    fmax;
        logic    fzero;
    } t_fin;

    localparam int SUM_W     = 20;
    localparam int CNT_W     = 8;
    localparam int PULLUP_W  = 20;
    localparam int COEF_W    = 48;
    localparam int TAG_W     = 8;
    localparam int TEMP_W    = 24;
    localparam int Q_SHIFT   = 16;  // resistance fraction bits
    localparam int FRAC_BITS = 24;  // log fraction bits
    localparam int XW        = 31;  // log mantissa width, Q30
    localparam int LW        = 29;  // |ln R| width, Q24
    localparam int L2W       = 34;  // |ln R|^2 width, Q24
    localparam int L3W       = 38;  // |ln R|^3 width, Q24
    localparam int DEN_W     = 62;  // positive denominator width, Q48

    localparam logic [29:0]       LN2_Q30  = 30'd744261118;
    localparam logic [TEMP_W-1:0] TEMP_MAX = 24'hFFFFFF;

endpackage

>>> rtl/ttc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module ttc_div_pipe #(
    parameter int NW = 20,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [DW-1:0] i_rem,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    logic [NW:0]   r_v;
    logic [NW-1:0] r_nq   [0:NW];
    logic [DW-1:0] r_rem  [0:NW];
    logic [DW-1:0] r_den  [0:NW];
    logic [SW-1:0] r_side [0:NW];

    logic [DW:0]   n_trial [0:NW-1];
    logic [DW:0]   n_diff  [0:NW-1];
    logic          n_ge    [0:NW-1];

    always_comb begin
        for (int k = 0; k < NW; k++) begin
            n_trial[k] = {r_rem[k], r_nq[k][NW-1]};
            n_diff[k]  = n_trial[k] - {1'b0, r_den[k]};
            n_ge[k]    = n_trial[k] >= {1'b0, r_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NW-1:0], i_valid};
        end
        r_nq[0]   <= i_num;
        r_rem[0]  <= i_rem;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int k = 0; k < NW; k++) begin
            r_rem[k+1]  <= n_ge[k] ? n_diff[k][DW-1:0] : n_trial[k][DW-1:0];
            r_nq[k+1]   <= {r_nq[k][NW-2:0], n_ge[k]};
            r_den[k+1]  <= r_den[k];
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_v[NW];
    assign o_quo   = r_nq[NW];
    assign o_side  = r_side[NW];

endmodule

>>> rtl/ttc_log_pipe.sv
// Pipelined natural log of a Q16 resistance: normalize, square-and-halve, scale by ln 2.
module ttc_log_pipe #(
    parameter int NW = 48,
    parameter int SW = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [NW-1:0]        i_rq,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic [ttc_pkg::LW-1:0] o_mag,
    output logic                 o_neg,
    output logic [SW-1:0]        o_side
);
    import ttc_pkg::*;

    localparam int S  = $clog2(NW);
    localparam int NI = FRAC_BITS;

    // normalize
    logic [S:0]    r_nv;
    logic [NW-1:0] r_nx [0:S];
    logic [S-1:0]  r_lz [0:S];
    logic [SW-1:0] r_ns [0:S];
    logic [NW-1:0] n_nx [0:S-1];
    logic [S-1:0]  n_lz [0:S-1];

    // square-and-halve
    logic [NI:0]          r_qv;
    logic [XW-1:0]        r_qx [0:NI];
    logic [FRAC_BITS-1:0] r_qf [0:NI];
    logic signed [7:0]    r_qe [0:NI];
    logic [SW-1:0]        r_qs [0:NI];
    logic [2*XW-1:0]      n_sq [0:NI-1];
    logic [XW:0]          n_t  [0:NI-1];

    // ln 2 scaling
    logic          r_m_v, r_p_v, r_r_v;
    logic          r_m_neg, r_p_neg, r_r_neg;
    logic [30:0]   r_m_mag;
    logic [60:0]   r_p;
    logic [LW-1:0] r_r_mag;
    logic [SW-1:0] r_m_s, r_p_s, r_r_s;

    logic signed [7:0] n_es;
    logic [31:0]       n_l2;
    logic [61:0]       n_rnd;

    always_comb begin
        for (int j = 0; j < S; j++) begin
            if ((r_nx[j] >> (NW - (1 << (S - 1 - j)))) == '0) begin
                n_nx[j] = r_nx[j] << (1 << (S - 1 - j));
                n_lz[j] = r_lz[j] | S'(1 << (S - 1 - j));
            end else begin
                n_nx[j] = r_nx[j];
                n_lz[j] = r_lz[j];
            end
        end
        for (int k = 0; k < NI; k++) begin
            n_sq[k] = r_qx[k] * r_qx[k];
            n_t[k]  = n_sq[k][2*XW-1:XW-1];
        end
        n_es  = 8'(NW - 17) - 8'(r_lz[S]);
        n_l2  = {r_qe[NI], r_qf[NI]};
        n_rnd = r_p_neg ? (62'(r_p) + 62'(32'h3FFF_FFFF)) : 62'(r_p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv  <= '0;
            r_qv  <= '0;
            r_m_v <= 1'b0;
            r_p_v <= 1'b0;
            r_r_v <= 1'b0;
        end else begin
            r_nv  <= {r_nv[S-1:0], i_valid};
            r_qv  <= {r_qv[NI-1:0], r_nv[S]};
            r_m_v <= r_qv[NI];
            r_p_v <= r_m_v;
            r_r_v <= r_p_v;
        end
        r_nx[0] <= i_rq;
        r_lz[0] <= '0;
        r_ns[0] <= i_side;
        for (int j = 0; j < S; j++) begin
            r_nx[j+1] <= n_nx[j];
            r_lz[j+1] <= n_lz[j];
            r_ns[j+1] <= r_ns[j];
        end
        r_qx[0] <= r_nx[S][NW-1 -: XW];
        r_qf[0] <= '0;
        r_qe[0] <= n_es;
        r_qs[0] <= r_ns[S];
        for (int k = 0; k < NI; k++) begin
            r_qx[k+1] <= n_t[k][XW] ? n_t[k][XW:1] : n_t[k][XW-1:0];
            r_qf[k+1] <= {r_qf[k][FRAC_BITS-2:0], n_t[k][XW]};
            r_qe[k+1] <= r_qe[k];
            r_qs[k+1] <= r_qs[k];
        end
        r_m_neg <= n_l2[31];
        r_m_mag <= n_l2[31] ? 31'(-n_l2) : n_l2[30:0];
        r_m_s   <= r_qs[NI];
        r_p     <= r_m_mag * LN2_Q30;
        r_p_neg <= r_m_neg;
        r_p_s   <= r_m_s;
        r_r_mag <= n_rnd[30 +: LW];
        r_r_neg <= r_p_neg;
        r_r_s   <= r_p_s;
    end

    assign o_valid = r_r_v;
    assign o_mag   = r_r_mag;
    assign o_neg   = r_r_neg;
    assign o_side  = r_r_s;

endmodule

>>> rtl/thermistor_temperature_converter.sv
// Top level: thermistor reading to Steinhart-Hart temperature, fully pipelined.
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+----------------------------
//  reading   | i_sample_sum, i_sample_count                   | beat when start && !busy
//  result    | o_temperature_q8, o_status, o_device_tag       | beat when o_done (1 cycle)
//  config    | psel penable pwrite paddr pwdata prdata pready | write: psel&penable&pwrite
//
//  One reading enters per clock; busy never rises. Each result leaves the pipe
//  after its beat by way of the three bit-per-stage dividers and the 24 squaring
//  stages of the log. Reset clears the valid bits and loads register defaults;
//  no clearing pass. The receiver cannot stall, so the pipe always advances.
module thermistor_temperature_converter #(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ttc_pkg::SUM_W-1:0]       i_sample_sum,
    input  logic [ttc_pkg::CNT_W-1:0]       i_sample_count,
    output logic                            o_done,
    output logic [ttc_pkg::TEMP_W-1:0]      o_temperature_q8,
    output logic [1:0]                      o_status,
    output logic [ttc_pkg::TAG_W-1:0]       o_device_tag,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [5:0]                      paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready
);
    import ttc_pkg::*;

    localparam int MW    = $clog2(ADC_FULL_SCALE + 1);  // mean width below full scale
    localparam int PW    = PULLUP_W + MW;               // pullup * mean
    localparam int RQ_W  = PW + Q_SHIFT;                // Q16 resistance
    localparam int LOG_S = $clog2(RQ_W);
    localparam int LAT   = (SUM_W + 1) + 1 + (RQ_W + 1) + (LOG_S + 29) + 8
                           + (FRAC_BITS + 1) + 1;
    localparam logic [SUM_W-1:0] FS_SUM = SUM_W'(ADC_FULL_SCALE);
    localparam logic [MW-1:0]    FS_M   = MW'(ADC_FULL_SCALE);
    localparam logic [63:0]      D_SAT  = 64'h1_0000_0000;  // positive D at or below this saturates

    // ---------------- configuration registers ----------------
    logic [PULLUP_W-1:0] r_pullup;
    logic [COEF_W-1:0]   r_coef_a, r_coef_b, r_coef_c;
    logic [TAG_W-1:0]    r_sensor_id;
    logic                cfg_wr;
    t_reg_idx            cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pullup    <= PULLUP_W'(10000);
            r_coef_a    <= '0;
            r_coef_b    <= '0;
            r_coef_c    <= '0;
            r_sensor_id <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PULLUP:    r_pullup    <= pwdata[PULLUP_W-1:0];
                REG_COEF_A:    r_coef_a    <= pwdata[COEF_W-1:0];
                REG_COEF_B:    r_coef_b    <= pwdata[COEF_W-1:0];
                REG_COEF_C:    r_coef_c    <= pwdata[COEF_W-1:0];
                REG_SENSOR_ID: r_sensor_id <= pwdata[TAG_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PULLUP:    prdata = 64'(r_pullup);
            REG_COEF_A:    prdata = 64'(r_coef_a);
            REG_COEF_B:    prdata = 64'(r_coef_b);
            REG_COEF_C:    prdata = 64'(r_coef_c);
            REG_SENSOR_ID: prdata = 64'(r_sensor_id);
            default:       prdata = '0;
        endcase
    end

    // ---------------- mean = sum / count ----------------
    logic             d1_v;
    logic [SUM_W-1:0] d1_mean;
    logic [0:0]       d1_side;

    ttc_div_pipe #(.NW(SUM_W), .DW(CNT_W), .SW(1)) u_mean_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_num   (i_sample_sum),
        .i_den   (i_sample_count),
        .i_rem   ('0),
        .i_side  (i_sample_count == '0),
        .o_valid (d1_v),
        .o_quo   (d1_mean),
        .o_side  (d1_side)
    );

    // ---------------- classify mean, form divider operands ----------------
    logic          r_b_v;
    t_status       r_b_st, n_b_st;
    logic [PW-1:0] r_b_prod;
    logic [MW-1:0] r_b_den;

    always_comb begin
        if (d1_side[0]) begin
            n_b_st = ST_NO_SAMPLES;
        end else if (d1_mean == '0 || d1_mean >= FS_SUM) begin
            n_b_st = ST_MEAN_RANGE;
        end else if (r_pullup == '0) begin
            n_b_st = ST_BAD_DENOM;  // zero resistance has no log
        end else begin
            n_b_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= d1_v;
        end
        r_b_st   <= n_b_st;
        r_b_prod <= r_pullup * d1_mean[MW-1:0];
        r_b_den  <= FS_M - d1_mean[MW-1:0];
    end

    // ---------------- Rq = pullup * m * 2^16 / (FS - m) ----------------
    logic            d2_v;
    logic [RQ_W-1:0] d2_rq;
    logic [1:0]      d2_side;

    ttc_div_pipe #(.NW(RQ_W), .DW(MW), .SW(2)) u_res_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_v),
        .i_num   ({r_b_prod, {Q_SHIFT{1'b0}}}),
        .i_den   (r_b_den),
        .i_rem   ('0),
        .i_side  (r_b_st),
        .o_valid (d2_v),
        .o_quo   (d2_rq),
        .o_side  (d2_side)
    );

    // ---------------- L = ln(R), Q24, sign and magnitude ----------------
    logic          lg_v, lg_neg;
    logic [LW-1:0] lg_mag;
    logic [1:0]    lg_side;

    ttc_log_pipe #(.NW(RQ_W), .SW(2)) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d2_v),
        .i_rq    (d2_rq),
        .i_side  (d2_side),
        .o_valid (lg_v),
        .o_mag   (lg_mag),
        .o_neg   (lg_neg),
        .o_side  (lg_side)
    );

    // ---------------- polynomial: D = a + b*L + c*L^3 ----------------
    // coefficient magnitudes; the user must keep the registers static while readings are in flight (not enforced)
    logic [COEF_W-1:0] b_mag, c_mag;
    logic              b_neg, c_neg;

    assign b_neg = r_coef_b[COEF_W-1];
    assign c_neg = r_coef_c[COEF_W-1];
    assign b_mag = b_neg ? COEF_W'(-r_coef_b) : r_coef_b;
    assign c_mag = c_neg ? COEF_W'(-r_coef_c) : r_coef_c;

    logic [7:0]     r_pv;  // valid bits of stages E through L
    t_status        r_e_st, r_f_st, r_g_st, r_h_st, r_i_st, r_j_st, r_k_st;
    logic           r_e_neg, r_f_neg, r_g_neg, r_h_neg, r_i_neg, r_j_neg;
    logic [LW-1:0]  r_e_l, r_f_l, r_g_l;
    logic [L2W-1:0] r_e_l2;
    logic [45:0]    r_f_ph, r_f_pl;
    logic [L3W-1:0] r_g_l3;
    logic [52:0]    r_h_bh, r_h_bl;
    logic [42:0]    r_h_chh, r_h_chl, r_h_clh, r_h_cll;
    logic [52:0]    r_i_tb, r_j_tb;
    logic [61:0]    r_i_cph, r_i_cpl, r_j_tc;
    logic signed [63:0] r_k_d;
    t_fin           r_l_fin, n_l_fin;
    logic [DEN_W-1:0] r_l_den;

    logic [2*LW-1:0]    n_e_sq;
    logic [62:0]        n_g_sum;
    logic signed [63:0] n_k_a, n_k_b, n_k_c;

    always_comb begin
        n_e_sq  = lg_mag * lg_mag;
        n_g_sum = {r_f_ph, 17'b0} + 63'(r_f_pl);
        // sign of each term: coefficient sign against sign of L (L^3 keeps it)
        n_k_a   = {{(64 - COEF_W){r_coef_a[COEF_W-1]}}, r_coef_a};
        n_k_b   = (b_neg != r_j_neg) ? -$signed(64'(r_j_tb)) : $signed(64'(r_j_tb));
        n_k_c   = (c_neg != r_j_neg) ? -$signed(64'(r_j_tc)) : $signed(64'(r_j_tc));
        n_l_fin.st    = r_k_st;
        n_l_fin.fmax  = 1'b0;
        n_l_fin.fzero = 1'b0;
        if (r_k_st != ST_OK) begin
            n_l_fin.fzero = 1'b1;
        end else if (r_k_d <= 64'sd0) begin
            n_l_fin.st    = ST_BAD_DENOM;
            n_l_fin.fzero = 1'b1;
        end else if ($unsigned(r_k_d) <= D_SAT) begin
            // quotient would not fit the output: saturate
            n_l_fin.st   = ST_BAD_DENOM;
            n_l_fin.fmax = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[6:0], lg_v};
        end
        // E: L^2
        r_e_st  <= t_status'(lg_side);
        r_e_neg <= lg_neg;
        r_e_l   <= lg_mag;
        r_e_l2  <= n_e_sq[FRAC_BITS +: L2W];
        // F: L^2 * L in two halves
        r_f_st  <= r_e_st;
        r_f_neg <= r_e_neg;
        r_f_l   <= r_e_l;
        r_f_ph  <= r_e_l2[L2W-1:17] * r_e_l;
        r_f_pl  <= r_e_l2[16:0] * r_e_l;
        // G: L^3
        r_g_st  <= r_f_st;
        r_g_neg <= r_f_neg;
        r_g_l   <= r_f_l;
        r_g_l3  <= n_g_sum[FRAC_BITS +: L3W];
        // H: partial products of b*L and c*L^3
        r_h_st  <= r_g_st;
        r_h_neg <= r_g_neg;
        r_h_bh  <= b_mag[47:24] * r_g_l;
        r_h_bl  <= b_mag[23:0] * r_g_l;
        r_h_chh <= c_mag[47:24] * r_g_l3[37:19];
        r_h_chl <= c_mag[47:24] * r_g_l3[18:0];
        r_h_clh <= c_mag[23:0] * r_g_l3[37:19];
        r_h_cll <= c_mag[23:0] * r_g_l3[18:0];
        // I: assemble halves
        r_i_st  <= r_h_st;
        r_i_neg <= r_h_neg;
        r_i_tb  <= r_h_bh + (r_h_bl >> FRAC_BITS);
        r_i_cph <= {r_h_chh, 19'b0} + 62'(r_h_chl);
        r_i_cpl <= {r_h_clh, 19'b0} + 62'(r_h_cll);
        // J: c term
        r_j_st  <= r_i_st;
        r_j_neg <= r_i_neg;
        r_j_tb  <= r_i_tb;
        r_j_tc  <= r_i_cph + (r_i_cpl >> FRAC_BITS);
        // K: denominator
        r_k_st  <= r_j_st;
        r_k_d   <= n_k_a + n_k_b + n_k_c;
        // L: classify
        r_l_fin <= n_l_fin;
        r_l_den <= r_k_d[DEN_W-1:0];
    end

    // ---------------- T = 2^56 / D ----------------
    // D above 2^32 leaves only 24 quotient bits: start with remainder 2^32
    logic              d3_v;
    logic [TEMP_W-1:0] d3_t;
    logic [$bits(t_fin)-1:0] d3_side;
    t_fin              d3_fin;

    ttc_div_pipe #(.NW(FRAC_BITS), .DW(DEN_W), .SW($bits(t_fin))) u_recip_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pv[7]),
        .i_num   ('0),
        .i_den   (r_l_den),
        .i_rem   (DEN_W'(D_SAT)),
        .i_side  (r_l_fin),
        .o_valid (d3_v),
        .o_quo   (d3_t),
        .o_side  (d3_side)
    );

    assign d3_fin = t_fin'(d3_side);

    // ---------------- result register ----------------
    logic              r_o_v;
    logic [TEMP_W-1:0] r_o_temp;
    t_status           r_o_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= d3_v;
        end
        r_o_st <= d3_fin.st;
        if (d3_fin.fzero) begin
            r_o_temp <= '0;
        end else if (d3_fin.fmax) begin
            r_o_temp <= TEMP_MAX;
        end else begin
            r_o_temp <= d3_t;
        end
    end

    assign o_done           = r_o_v;
    assign o_temperature_q8 = r_o_temp;
    assign o_status         = r_o_st;
    assign o_device_tag     = r_sensor_id;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("reading did not produce a result after the pipeline latency");

    a_no_samples_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_NO_SAMPLES) |-> (o_temperature_q8 == '0))
        else $error("no-samples result carries a temperature");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_MEAN_RANGE) |-> (o_temperature_q8 == '0))
        else $error("mean-out-of-range result carries a temperature");

    a_bad_denom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_BAD_DENOM)
        |-> (o_temperature_q8 == '0 || o_temperature_q8 == TEMP_MAX))
        else $error("bad-denominator result is neither zero nor saturated");

endmodule
